FILE: sv/dtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants for the decimal text to Q8.8 converter.
// ----------------------------------------------------------------------------
package dtq_pkg;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FORMAT = 2'd1,
    STATUS_RANGE  = 2'd2
  } status_t;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned POS_W = 4;
  localparam int unsigned INT_W = 10;
  localparam int unsigned FRAC_W = 14;

  localparam logic [POS_W-1:0] POS_SIGN  = 4'd0;
  localparam logic [POS_W-1:0] POS_POINT = 4'd4;
  localparam logic [POS_W-1:0] POS_LAST  = 4'd8;
  localparam logic [POS_W-1:0] POS_END   = 4'd9;
  localparam logic [POS_W-1:0] POS_MAX   = 4'd15;

  localparam logic [INT_W-1:0]  INT_LIMIT     = 10'd127;
  localparam logic [INT_W-1:0]  NEG_INT_LIMIT = 10'd128;
  localparam logic [FRAC_W-1:0] FRAC_LIMIT    = 14'd9960;

  // floor(f * 16 / 625) as a reciprocal multiply, exact for f * 16 below 2^28 / 169
  localparam int unsigned RECIP_W = 19;
  localparam int unsigned PROD_W  = FRAC_W + 4 + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] FRAC_RECIP = 19'd429497;

endpackage

FILE: sv/dtq_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_char_if
// Valid/ready channel carrying one text character per item.
// ----------------------------------------------------------------------------
interface dtq_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

FILE: sv/dtq_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_result_if
// Valid/ready channel carrying one Q8.8 word and its status per item.
// ----------------------------------------------------------------------------
interface dtq_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] fixed_value;
  logic        [1:0]  status;

  modport source (output valid, output fixed_value, output status, input ready);
  modport sink   (input valid, input fixed_value, input status, output ready);
endinterface

FILE: sv/decimal_text_to_q8_8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_q8_8
// Parses fixed-form decimal text (sign, three digits, point, four digits)
// and returns a two's complement Q8.8 word with an ok/format/range status.
//
// channel   direction  item
// text      in         character, last_char
// result    out        fixed_value, status (one item per last character)
//
// one character is taken every cycle unless text stalls; the parse state updates at the accept
// a last character loads a snapshot register, the conversion runs from there
// into the output register that drives result
// text stalls only while both the snapshot and a waiting result are full
// rst is synchronous and clears the parse state and both valid flags
// ----------------------------------------------------------------------------
module decimal_text_to_q8_8 import dtq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  dtq_char_if.sink     text,
  dtq_result_if.source result
);

  // parse state
  logic [POS_W-1:0]  position, position_next;
  logic              negative_sign, negative_sign_next;
  logic              format_bad, format_bad_next;
  logic [INT_W-1:0]  integer_digits, integer_digits_next;
  logic [FRAC_W-1:0] fraction_digits, fraction_digits_next;

  // snapshot of a finished string
  logic              snap_valid;
  logic              snap_neg;
  logic              snap_bad;
  logic [INT_W-1:0]  snap_int;
  logic [FRAC_W-1:0] snap_frac;

  logic              accept;
  logic              out_free;
  logic              is_digit;
  logic [3:0]        digit;

  logic [PROD_W-1:0] frac_prod;
  logic [8:0]        frac_bits;
  logic [15:0]       word;
  logic [15:0]       value_next;
  status_t           status_next;

  assign out_free   = !result.valid || result.ready;
  assign text.ready = !snap_valid || out_free;
  assign accept     = text.valid && text.ready;

  assign is_digit = (text.character >= CHAR_ZERO) && (text.character <= CHAR_NINE);
  assign digit    = text.character[3:0];

  always_comb begin
    negative_sign_next   = negative_sign;
    format_bad_next      = format_bad;
    integer_digits_next  = integer_digits;
    fraction_digits_next = fraction_digits;
    priority if (position == POS_SIGN) begin
      if (text.character == CHAR_MINUS) begin
        negative_sign_next = 1'b1;
      end else if (text.character != CHAR_PLUS) begin
        format_bad_next = 1'b1;
      end
    end else if (position == POS_POINT) begin
      if (text.character != CHAR_POINT) begin
        format_bad_next = 1'b1;
      end
    end else if (position < POS_END) begin
      if (!is_digit) begin
        format_bad_next = 1'b1;
      end else if (position < POS_POINT) begin
        integer_digits_next = (integer_digits << 3) + (integer_digits << 1)
                              + {{(INT_W-4){1'b0}}, digit};
      end else begin
        fraction_digits_next = (fraction_digits << 3) + (fraction_digits << 1)
                               + {{(FRAC_W-4){1'b0}}, digit};
      end
    end else begin
      format_bad_next = 1'b1;
    end
    position_next = (position == POS_MAX) ? POS_MAX : position + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      negative_sign   <= 1'b0;
      format_bad      <= 1'b0;
      integer_digits  <= '0;
      fraction_digits <= '0;
    end else if (accept) begin
      if (text.last_char) begin
        position        <= '0;
        negative_sign   <= 1'b0;
        format_bad      <= 1'b0;
        integer_digits  <= '0;
        fraction_digits <= '0;
      end else begin
        position        <= position_next;
        negative_sign   <= negative_sign_next;
        format_bad      <= format_bad_next;
        integer_digits  <= integer_digits_next;
        fraction_digits <= fraction_digits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && text.last_char) begin
      snap_valid <= 1'b1;
    end else if (out_free) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text.last_char) begin
      snap_neg  <= negative_sign_next;
      snap_bad  <= format_bad_next || (position != POS_LAST);
      snap_int  <= integer_digits_next;
      snap_frac <= fraction_digits_next;
    end
  end

  // conversion
  assign frac_prod = PROD_W'({snap_frac, 4'b0000}) * PROD_W'(FRAC_RECIP);
  assign frac_bits = frac_prod[RECIP_SHIFT +: 9];
  assign word      = {1'b0, snap_int[6:0], 8'h00} + {7'b0000000, frac_bits};

  always_comb begin
    value_next  = '0;
    status_next = STATUS_OK;
    priority if (snap_bad) begin
      status_next = STATUS_FORMAT;
    end else if (!snap_neg && ((snap_int > INT_LIMIT)
                 || ((snap_int == INT_LIMIT) && (snap_frac > FRAC_LIMIT)))) begin
      status_next = STATUS_RANGE;
    end else if (snap_neg && (snap_int >= NEG_INT_LIMIT)) begin
      status_next = STATUS_RANGE;
    end else begin
      value_next = snap_neg ? (~word + 16'd1) : word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_valid) begin
      result.fixed_value <= value_next;
      result.status      <= status_next;
    end
  end

endmodule
